// ----- src/stepper_wave_drive_sequencer_assert.svh -----
// Assertion macros used by the sequencer core (swds_core).
// Each use expects clk and rst_n in scope.
`ifndef STEPPER_WAVE_DRIVE_SEQUENCER_ASSERT_SVH
`define STEPPER_WAVE_DRIVE_SEQUENCER_ASSERT_SVH

`ifndef SYNTHESIS

`define SWDS_ASSERT_ALWAYS(name, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("swds: invariant violated");

`define SWDS_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("swds: implication violated");

`else

`define SWDS_ASSERT_ALWAYS(name, expr)

`define SWDS_ASSERT_IMPL(name, ante, cons)

`endif

`endif

// ----- src/swds_pkg.sv -----
package swds_pkg;

    // Character codes and entry radix
    localparam logic [7:0] CHAR_CR    = 8'd13;
    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_NINE  = 8'd57;
    localparam logic [6:0] DIGIT_BASE = 7'd10;

    // Saturation limit of the entry byte count
    localparam logic [3:0] COUNT_MAX = 4'd15;

    // Item kinds on the input tuser bit
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef enum logic [1:0] {
        MODE_ENTRY = 2'd0,
        MODE_FWD   = 2'd1,
        MODE_WAIT  = 2'd2,
        MODE_HOME  = 2'd3
    } mode_t;

    // One result item as produced by the sequencer core
    typedef struct packed {
        logic        entry_error;
        logic        busy_res;
        mode_t       mode;
        logic [7:0]  echo_byte;
        logic        echo_valid;
        logic [3:0]  coils;
    } swds_result_t;

endpackage

// ----- src/stepper_wave_drive_sequencer.sv -----
// Path: an accepted item is held in the input register until the output register
// has room; the sequencer updates in one pass and the result lands in the output
// register. Throughput: one item per cycle unless a low m_axis_tready stalls it.
// Reset: asynchronous, active low; mode returns to entry, counts, target, phase
// and coils clear, and both pipeline registers empty.
module stepper_wave_drive_sequencer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic        s_axis_tuser,   // [0] op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [3:0] coils, [11:4] echo_byte, [13:12] mode,
                                        // [14] busy_res, [15] entry_error
    output logic        m_axis_tuser    // [0] echo_valid
);

    logic                   in_valid_reg;
    logic                   in_op_reg;
    logic [7:0]             in_byte_reg;
    logic                   out_valid_reg;
    swds_pkg::swds_result_t out_reg;
    swds_pkg::swds_result_t result;
    logic                   advance;
    logic                   in_take;

    // Move the held item into the output register when it has room
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_op_reg   <= s_axis_tuser;
            in_byte_reg <= s_axis_tdata;
        end
    end

    swds_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .op      (in_op_reg),
        .rx_byte (in_byte_reg),
        .result  (result)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_reg <= result;
    end

    // Drive the result port
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.echo_valid;
    assign m_axis_tdata  = {out_reg.entry_error, out_reg.busy_res, out_reg.mode,
                            out_reg.echo_byte, out_reg.coils};

endmodule

// ----- src/swds_core.sv -----
module swds_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step_en,
    input  logic                  op,
    input  logic [7:0]            rx_byte,
    output swds_pkg::swds_result_t result
);

`include "stepper_wave_drive_sequencer_assert.svh"

    swds_pkg::mode_t mode_reg, mode_next;
    logic [7:0] digit_reg [2];
    logic [3:0] entry_count_reg, entry_count_next;
    logic [6:0] target_reg, target_next;
    logic [6:0] step_count_reg, step_count_next;
    logic [1:0] phase_reg, phase_next;
    logic [3:0] coil_reg, coil_next;
    logic       error_reg, error_next;
    logic       digit_we;
    logic       echo_valid;
    logic [7:0] echo_byte;
    logic       d0_ok, d1_ok;
    logic [3:0] d0_val, d1_val;
    logic [6:0] entry_target;
    logic       entry_ok;

    // Decode the kept digits into a target
    always_comb
    begin
        logic [7:0] diff0;
        logic [7:0] diff1;
        diff0 = digit_reg[0] - swds_pkg::CHAR_ZERO;
        diff1 = digit_reg[1] - swds_pkg::CHAR_ZERO;
        d0_ok  = digit_reg[0] inside {[swds_pkg::CHAR_ZERO:swds_pkg::CHAR_NINE]};
        d1_ok  = digit_reg[1] inside {[swds_pkg::CHAR_ZERO:swds_pkg::CHAR_NINE]};
        d0_val = diff0[3:0];
        d1_val = diff1[3:0];
        entry_ok     = 1'b0;
        entry_target = '0;
        if (entry_count_reg == 4'd1 && d0_ok)
        begin
            entry_ok     = 1'b1;
            entry_target = {3'b000, d0_val};
        end
        else if (entry_count_reg == 4'd2 && d0_ok && d1_ok)
        begin
            entry_ok     = 1'b1;
            entry_target = 7'({3'b000, d0_val} * swds_pkg::DIGIT_BASE) + {3'b000, d1_val};
        end
    end

    // Next state and result for the item at hand
    always_comb
    begin
        logic [6:0] sc;
        mode_next        = mode_reg;
        entry_count_next = entry_count_reg;
        target_next      = target_reg;
        step_count_next  = step_count_reg;
        phase_next       = phase_reg;
        coil_next        = coil_reg;
        error_next       = error_reg;
        digit_we         = 1'b0;
        echo_valid       = 1'b0;
        echo_byte        = '0;
        sc               = step_count_reg;
        if (op == swds_pkg::OP_BYTE)
        begin
            case (mode_reg)
                swds_pkg::MODE_ENTRY:
                begin
                    if (rx_byte == swds_pkg::CHAR_CR)
                    begin
                        target_next      = entry_target;
                        error_next       = !entry_ok;
                        entry_count_next = '0;
                        mode_next        = (step_count_reg >= entry_target) ?
                                           swds_pkg::MODE_WAIT : swds_pkg::MODE_FWD;
                    end
                    else
                    begin
                        echo_valid = 1'b1;
                        echo_byte  = rx_byte;
                        digit_we   = (entry_count_reg < 4'd2);
                        if (entry_count_reg < swds_pkg::COUNT_MAX)
                            entry_count_next = entry_count_reg + 4'd1;
                    end
                end
                swds_pkg::MODE_WAIT:
                begin
                    if (rx_byte == swds_pkg::CHAR_CR)
                    begin
                        phase_next = phase_reg + 2'd2;
                        mode_next  = (step_count_reg == '0) ?
                                     swds_pkg::MODE_ENTRY : swds_pkg::MODE_HOME;
                    end
                end
                default:
                begin
                end
            endcase
        end
        else
        begin
            case (mode_reg)
                swds_pkg::MODE_FWD:
                begin
                    coil_next       = 4'b0001 << phase_reg;
                    phase_next      = phase_reg + 2'd1;
                    sc              = step_count_reg + 7'd1;
                    step_count_next = sc;
                    if (sc >= target_reg)
                        mode_next = swds_pkg::MODE_WAIT;
                end
                swds_pkg::MODE_HOME:
                begin
                    coil_next  = 4'b0001 << phase_reg;
                    phase_next = phase_reg - 2'd1;
                    if (step_count_reg != '0)
                        sc = step_count_reg - 7'd1;
                    step_count_next = sc;
                    if (sc == '0)
                        mode_next = swds_pkg::MODE_ENTRY;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Assemble the result from the updated state
    always_comb
    begin
        result.coils       = coil_next;
        result.echo_valid  = echo_valid;
        result.echo_byte   = echo_byte;
        result.mode        = mode_next;
        result.busy_res    = (mode_next == swds_pkg::MODE_FWD) ||
                             (mode_next == swds_pkg::MODE_HOME);
        result.entry_error = error_next;
    end

    // Hold control state, advance on each item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= swds_pkg::MODE_ENTRY;
            entry_count_reg <= '0;
            target_reg      <= '0;
            step_count_reg  <= '0;
            phase_reg       <= '0;
            coil_reg        <= '0;
            error_reg       <= 1'b0;
        end
        else if (step_en)
        begin
            mode_reg        <= mode_next;
            entry_count_reg <= entry_count_next;
            target_reg      <= target_next;
            step_count_reg  <= step_count_next;
            phase_reg       <= phase_next;
            coil_reg        <= coil_next;
            error_reg       <= error_next;
        end
    end

    // Keep the first two entry bytes
    always_ff @(posedge clk)
    begin
        if (step_en && digit_we)
            digit_reg[entry_count_reg[0]] <= rx_byte;
    end

    `SWDS_ASSERT_ALWAYS(a_coils_onehot0, $onehot0(coil_reg))
    `SWDS_ASSERT_IMPL(a_fwd_below_target, mode_reg == swds_pkg::MODE_FWD, step_count_reg < target_reg)
    `SWDS_ASSERT_IMPL(a_home_not_zero, mode_reg == swds_pkg::MODE_HOME, step_count_reg != '0)
    `SWDS_ASSERT_IMPL(a_entry_at_home, mode_reg == swds_pkg::MODE_ENTRY, step_count_reg == '0)

endmodule
